// ===== hw/rtl/carm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cardan rotation matrix package
// Shared constants, types, the CORDIC arctangent table and a rounding Q30 multiply.
// ----------------------------------------------------------------------------
package carm_pkg;

  localparam int AngleBitsDef    = 16;
  localparam int FracBitsDef     = 14;
  localparam int CordicStagesDef = 16;

  // Q30 working width: sign, two integer bits of headroom, 30 fraction bits
  localparam int WBits = 33;
  localparam int ZBits = 33;
  localparam logic signed [WBits-1:0] CordicGain = 33'sd652032874;

  typedef logic signed [WBits-1:0] wrd_t;
  typedef logic signed [ZBits-1:0] zrd_t;

  // One cell's state for one angle
  typedef struct packed {
    wrd_t       x;
    wrd_t       y;
    zrd_t       z;
    logic [1:0] quad;
  } cdc_lane_t;

  // arctan(2^-i) in 2^-32 turn units
  function automatic zrd_t atan_tab(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      30: v = 32'h00000001;  default: v = 32'h00000000;
    endcase
    return zrd_t'({1'b0, v});
  endfunction

  // Rounded Q30 x Q30 -> Q30 product
  function automatic wrd_t mul30(input wrd_t a, input wrd_t b);
    logic signed [2*WBits-1:0] p;
    p = (2*WBits)'(a) * (2*WBits)'(b) + (2*WBits)'(64'sd1 <<< 29);
    return wrd_t'(p >>> 30);
  endfunction

endpackage

// ===== hw/rtl/carm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valid/ready channel
// Generic handshake channel carrying one payload of type PT.
// ----------------------------------------------------------------------------
interface carm_if #(
  parameter type PT = logic
);
  logic valid;
  logic ready;
  PT    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/carm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation for the three angle lanes; hands state to the next cell.
// ----------------------------------------------------------------------------
module carm_cell import carm_pkg::*; #(
  parameter int unsigned Shift = 0
) (
  input  logic      clk_i,
  input  logic      en_i,
  input  cdc_lane_t lane_i [3],
  output cdc_lane_t lane_o [3]
);

  cdc_lane_t lane_d [3];
  cdc_lane_t lane_q [3];

  // Rotate each lane toward z = 0
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_d[k].quad = lane_i[k].quad;
      if (!lane_i[k].z[ZBits-1]) begin
        lane_d[k].x = lane_i[k].x - (lane_i[k].y >>> Shift);
        lane_d[k].y = lane_i[k].y + (lane_i[k].x >>> Shift);
        lane_d[k].z = lane_i[k].z - atan_tab(Shift);
      end else begin
        lane_d[k].x = lane_i[k].x + (lane_i[k].y >>> Shift);
        lane_d[k].y = lane_i[k].y - (lane_i[k].x >>> Shift);
        lane_d[k].z = lane_i[k].z + atan_tab(Shift);
      end
    end
  end

  // Advance when the pipeline moves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== hw/rtl/carm_mat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix back end
// Quadrant fix-up, registered product stages and output rounding/saturation.
// ----------------------------------------------------------------------------
module carm_mat import carm_pkg::*; #(
  parameter int FracBits = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  cdc_lane_t               lane_i [3],
  output logic signed [FracBits+1:0] m_o [9]
);

  localparam int OBits = FracBits + 2;
  localparam int Sh    = 30 - FracBits;

  wrd_t c_d [3], s_d [3];
  wrd_t c_q [3], s_q [3];
  wrd_t sasb_q, casb_q, cb1_q, sb1_q, ca1_q, sa1_q, cg1_q, sg1_q;
  wrd_t e_d [9], e_q [9];
  logic signed [OBits-1:0] o_d [9];

  // Map the quadrant back onto cos/sin
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (lane_i[k].quad)
        2'd0: begin c_d[k] =  lane_i[k].x; s_d[k] =  lane_i[k].y; end
        2'd1: begin c_d[k] = -lane_i[k].y; s_d[k] =  lane_i[k].x; end
        2'd2: begin c_d[k] = -lane_i[k].x; s_d[k] = -lane_i[k].y; end
        default: begin c_d[k] = lane_i[k].y; s_d[k] = -lane_i[k].x; end
      endcase
    end
  end

  // Second-level products from sa*sb and ca*sb
  always_comb begin
    e_d[0] = mul30(cb1_q, cg1_q);
    e_d[1] = mul30(sasb_q, cg1_q) + mul30(ca1_q, sg1_q);
    e_d[2] = -mul30(casb_q, cg1_q) + mul30(sa1_q, sg1_q);
    e_d[3] = -mul30(cb1_q, sg1_q);
    e_d[4] = -mul30(sasb_q, sg1_q) + mul30(ca1_q, cg1_q);
    e_d[5] = mul30(casb_q, sg1_q) + mul30(sa1_q, cg1_q);
    e_d[6] = sb1_q;
    e_d[7] = -mul30(sa1_q, cb1_q);
    e_d[8] = mul30(ca1_q, cb1_q);
  end

  // Round to the output format and clamp to +-1.0
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      wrd_t r;
      r = (e_q[k] + wrd_t'(64'sd1 <<< (Sh - 1))) >>> Sh;
      if (r > wrd_t'(64'sd1 <<< FracBits)) begin
        r = wrd_t'(64'sd1 <<< FracBits);
      end else if (r < -wrd_t'(64'sd1 <<< FracBits)) begin
        r = -wrd_t'(64'sd1 <<< FracBits);
      end
      o_d[k] = r[OBits-1:0];
    end
  end

  // Pipeline registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q    <= c_d;
      s_q    <= s_d;
      sasb_q <= mul30(s_q[0], s_q[1]);
      casb_q <= mul30(c_q[0], s_q[1]);
      ca1_q  <= c_q[0];
      sa1_q  <= s_q[0];
      cb1_q  <= c_q[1];
      sb1_q  <= s_q[1];
      cg1_q  <= c_q[2];
      sg1_q  <= s_q[2];
      e_q    <= e_d;
      m_o    <= o_d;
    end
  end

endmodule

// ===== hw/rtl/cardan_angles_rotation_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cardan angles rotation matrix
// x-y-z Cardan angles in, 3x3 rotation matrix in Q1.FRAC_BITS out.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_if   | in  | angle_alpha, angle_beta, angle_gamma (binary angles)
//  out_if  | out | m00 .. m22 (signed Q1.FRAC_BITS)
//
//  One transaction per cycle sustained while the output is not stalled.
//  The CORDIC cell chain plus four back-end stages set the latency.
//  Reset clears only the valid bits of the pipeline.
//  A stall at the output freezes the whole pipeline (the last stage is the
//  output register), so input ready follows output ready while the output is valid.
// ----------------------------------------------------------------------------
module cardan_angles_rotation_matrix import carm_pkg::*; #(
  parameter int ANGLE_BITS    = AngleBitsDef,
  parameter int FRAC_BITS     = FracBitsDef,
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  carm_if.sink   in_if,
  carm_if.source out_if
);

  localparam int NStg  = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int Depth = NStg + 4;

  cdc_lane_t       lane0 [3];
  cdc_lane_t       chain [NStg+1][3];
  logic [Depth-1:0] vld_q;
  logic            en;
  logic signed [FRAC_BITS+1:0] m [9];

  assign en          = out_if.ready || !vld_q[Depth-1];
  assign in_if.ready = en;

  // Align each angle to a 32-bit turn and split off the quadrant
  always_comb begin
    logic [31:0] a32 [3];
    a32[0] = 32'(in_if.data.angle_alpha[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    a32[1] = 32'(in_if.data.angle_beta[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    a32[2] = 32'(in_if.data.angle_gamma[ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    for (int k = 0; k < 3; k++) begin
      lane0[k].quad = a32[k][31:30];
      lane0[k].x    = CordicGain;
      lane0[k].y    = '0;
      lane0[k].z    = zrd_t'({3'b000, a32[k][29:0]});
    end
  end

  assign chain[0] = lane0;

  // Chain of micro-rotation cells
  for (genvar i = 0; i < NStg; i++) begin : g_cell
    carm_cell #(.Shift(i)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (chain[i]),
      .lane_o (chain[i+1])
    );
  end

  carm_mat #(.FracBits(FRAC_BITS)) u_mat (
    .clk_i  (clk_i),
    .en_i   (en),
    .lane_i (chain[NStg]),
    .m_o    (m)
  );

  // Track occupancy of each stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  assign out_if.valid    = vld_q[Depth-1];
  assign out_if.data.m00 = m[0];
  assign out_if.data.m10 = m[1];
  assign out_if.data.m20 = m[2];
  assign out_if.data.m01 = m[3];
  assign out_if.data.m11 = m[4];
  assign out_if.data.m21 = m[5];
  assign out_if.data.m02 = m[6];
  assign out_if.data.m12 = m[7];
  assign out_if.data.m22 = m[8];

endmodule

// ===== hw/rtl/carm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Handshake and range checks on the top-level channels.
// ----------------------------------------------------------------------------
module carm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic signed [15:0] m02_i,
  input logic signed [15:0] m00_i
);

  // A stalled output stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped under stall");

  // Input is taken whenever output is free
  a_in_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // Entries m00 and m02 stay within +-1.0
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (m02_i <= 16'sd16384 && m02_i >= -16'sd16384 &&
                     m00_i <= 16'sd16384 && m00_i >= -16'sd16384))
    else $error("matrix entry out of range");

endmodule

bind cardan_angles_rotation_matrix carm_checker u_carm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .m02_i       (out_if.data.m02),
  .m00_i       (out_if.data.m00)
);
